>>> rtl/core/triangle_face_normal_defines.svh
// assertion macros for the triangle face normal block
// used by the modules that carry concurrent checks; needs clk_i and rst_ni in scope
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TFN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tfn check failed");
`define TFN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tfn check failed");
`else
`define TFN_ASSERT(lbl, prop)
`define TFN_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/core/tfn_pkg.sv
// shared types for the triangle face normal pipeline
// no dependencies
package tfn_pkg;

  localparam int InWidth  = 32;
  localparam int OutWidth = 16;

  typedef struct packed {
    logic [InWidth-1:0] first_x;
    logic [InWidth-1:0] first_y;
    logic [InWidth-1:0] first_z;
    logic [InWidth-1:0] second_x;
    logic [InWidth-1:0] second_y;
    logic [InWidth-1:0] second_z;
    logic [InWidth-1:0] third_x;
    logic [InWidth-1:0] third_y;
    logic [InWidth-1:0] third_z;
  } tfn_in_t;

  typedef struct packed {
    logic [OutWidth-1:0] normal_x;
    logic [OutWidth-1:0] normal_y;
    logic [OutWidth-1:0] normal_z;
    logic                degenerate;
  } tfn_out_t;

endpackage

>>> rtl/core/tfn_cross.sv
// edge vectors, cross product and component magnitudes, four register stages
// depends on tfn_pkg
module tfn_cross import tfn_pkg::*; #(
  parameter int CoordWidth = 32
) (
  input  logic                      clk_i,
  input  logic [3:0]                en_i,
  input  tfn_in_t                   data_i,
  output logic [2*CoordWidth+1:0]   mag_o [3],
  output logic                      neg_o [3]
);

  localparam int EW = CoordWidth + 1;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;
  localparam int MW = PW;

  function automatic logic signed [EW-1:0] ext(input logic [InWidth-1:0] w);
    return EW'($signed(w[CoordWidth-1:0]));
  endfunction

  logic signed [EW-1:0] ea_q [3];
  logic signed [EW-1:0] eb_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic signed [NW-1:0] n_q  [3];
  logic [MW-1:0]        mag_q [3];
  logic                 neg_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ea_q[0] <= ext(data_i.first_x) - ext(data_i.second_x);
      ea_q[1] <= ext(data_i.first_y) - ext(data_i.second_y);
      ea_q[2] <= ext(data_i.first_z) - ext(data_i.second_z);
      eb_q[0] <= ext(data_i.second_x) - ext(data_i.third_x);
      eb_q[1] <= ext(data_i.second_y) - ext(data_i.third_y);
      eb_q[2] <= ext(data_i.second_z) - ext(data_i.third_z);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (en_i[1]) begin
        pa_q[i] <= PW'(ea_q[J]) * PW'(eb_q[K]);
        pb_q[i] <= PW'(ea_q[K]) * PW'(eb_q[J]);
      end
      if (en_i[2]) begin
        n_q[i] <= NW'(pa_q[i]) - NW'(pb_q[i]);
      end
      if (en_i[3]) begin
        neg_q[i] <= n_q[i][NW-1];
        mag_q[i] <= n_q[i][NW-1] ? MW'(-n_q[i]) : MW'(n_q[i]);
      end
    end

    assign mag_o[i] = mag_q[i];
    assign neg_o[i] = neg_q[i];
  end

endmodule

>>> rtl/core/tfn_norm_sq.sv
// squared length of the cross product and seed values for the digit recurrence
// depends on tfn_pkg
module tfn_norm_sq import tfn_pkg::*; #(
  parameter int CoordWidth = 32,
  parameter int FracBits   = 14
) (
  input  logic                                      clk_i,
  input  logic [3:0]                                en_i,
  input  logic [2*CoordWidth+1:0]                   mag_i [3],
  input  logic                                      neg_i [3],
  output logic signed [4*CoordWidth+2*FracBits+11:0] rem_o [3],
  output logic signed [4*CoordWidth+2*FracBits+11:0] acc_o [3],
  output logic [4*CoordWidth+3:0]                   sum_o,
  output logic                                      neg_o [3],
  output logic                                      deg_o
);

  localparam int EW  = CoordWidth + 1;
  localparam int HW  = EW;
  localparam int SQW = 4 * EW;
  localparam int SW  = SQW;
  localparam int RW  = 4 * EW + 2 * FracBits + 8;

  logic [2*HW-1:0] hh_q [3];
  logic [2*HW-1:0] hl_q [3];
  logic [2*HW-1:0] ll_q [3];
  logic            neg5_q [3];
  logic [SQW-1:0]  sq6_q [3];
  logic            neg6_q [3];
  logic [SQW-1:0]  sq7_q [3];
  logic            neg7_q [3];
  logic [SW-1:0]   sum7_q;
  logic [SW-1:0]   sum_q;
  logic signed [RW-1:0] rem_q [3];
  logic signed [RW-1:0] acc_q [3];
  logic            neg_q [3];
  logic            deg_q;

  for (genvar i = 0; i < 3; i++) begin : g_comp
    logic [HW-1:0] mh, ml;
    assign mh = mag_i[i][2*HW-1:HW];
    assign ml = mag_i[i][HW-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        hh_q[i]   <= (2*HW)'(mh) * (2*HW)'(mh);
        hl_q[i]   <= (2*HW)'(mh) * (2*HW)'(ml);
        ll_q[i]   <= (2*HW)'(ml) * (2*HW)'(ml);
        neg5_q[i] <= neg_i[i];
      end
      if (en_i[1]) begin
        sq6_q[i]  <= (SQW'(hh_q[i]) << (2 * HW)) + (SQW'(hl_q[i]) << (HW + 1))
                     + SQW'(ll_q[i]);
        neg6_q[i] <= neg5_q[i];
      end
      if (en_i[2]) begin
        sq7_q[i]  <= sq6_q[i];
        neg7_q[i] <= neg6_q[i];
      end
      // residual starts at 4^(F+1) m^2 - S, running product at -S (quotient zero)
      if (en_i[3]) begin
        rem_q[i] <= $signed((RW'(sq7_q[i]) << (2 * FracBits + 2)) - RW'(sum7_q));
        acc_q[i] <= $signed(RW'(0) - RW'(sum7_q));
        neg_q[i] <= neg7_q[i];
      end
    end

    assign rem_o[i] = rem_q[i];
    assign acc_o[i] = acc_q[i];
    assign neg_o[i] = neg_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sum7_q <= sq6_q[0] + sq6_q[1] + sq6_q[2];
    end
    if (en_i[3]) begin
      sum_q <= sum7_q;
      deg_q <= (sum7_q == '0);
    end
  end

  assign sum_o = sum_q;
  assign deg_o = deg_q;

endmodule

>>> rtl/core/tfn_root_stage.sv
// one quotient bit of round(2^F m / sqrt(S)) for all three components
// depends on tfn_pkg
module tfn_root_stage import tfn_pkg::*; #(
  parameter int CoordWidth = 32,
  parameter int FracBits   = 14,
  parameter int Bit        = 0
) (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  logic signed [4*CoordWidth+2*FracBits+11:0] rem_i [3],
  input  logic signed [4*CoordWidth+2*FracBits+11:0] acc_i [3],
  input  logic [FracBits:0]                          quo_i [3],
  input  logic [4*CoordWidth+3:0]                    sum_i,
  input  logic                                       neg_i [3],
  input  logic                                       deg_i,
  output logic signed [4*CoordWidth+2*FracBits+11:0] rem_o [3],
  output logic signed [4*CoordWidth+2*FracBits+11:0] acc_o [3],
  output logic [FracBits:0]                          quo_o [3],
  output logic [4*CoordWidth+3:0]                    sum_o,
  output logic                                       neg_o [3],
  output logic                                       deg_o
);

  localparam int RW = 4 * CoordWidth + 2 * FracBits + 12;
  localparam int QW = FracBits + 1;

  logic signed [RW-1:0] rem_q [3];
  logic signed [RW-1:0] acc_q [3];
  logic [QW-1:0]        quo_q [3];
  logic [4*CoordWidth+3:0] sum_q;
  logic                 neg_q [3];
  logic                 deg_q;
  logic signed [RW-1:0] sum_sq;
  logic signed [RW-1:0] sum_lin;

  assign sum_sq  = $signed(RW'(sum_i) << (2 * Bit + 2));
  assign sum_lin = $signed(RW'(sum_i) << (Bit + 1));

  for (genvar i = 0; i < 3; i++) begin : g_comp
    // (u+d)^2 S - u^2 S = 2d(uS) + d^2 S with d = 2^(Bit+1)
    logic signed [RW-1:0] step;
    logic                 take;
    assign step = (acc_i[i] <<< (Bit + 2)) + sum_sq;
    assign take = (step <= rem_i[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= take ? rem_i[i] - step : rem_i[i];
        acc_q[i] <= take ? acc_i[i] + sum_lin : acc_i[i];
        quo_q[i] <= take ? (quo_i[i] | (QW'(1) << Bit)) : quo_i[i];
        neg_q[i] <= neg_i[i];
      end
    end

    assign rem_o[i] = rem_q[i];
    assign acc_o[i] = acc_q[i];
    assign quo_o[i] = quo_q[i];
    assign neg_o[i] = neg_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_i;
      deg_q <= deg_i;
    end
  end

  assign sum_o = sum_q;
  assign deg_o = deg_q;

endmodule

>>> rtl/core/triangle_face_normal.sv
// triangle face normal: NORMAL_FRAC_BITS + 10 register stages from the accepted
// input transaction to valid_o. one transaction per cycle unless stall_o is
// high, since every stage is pipelined; the rounding recurrence takes one stage
// per quotient bit. stall_i reaches stall_o in the same cycle only when every
// stage is full; empty stages still fill.
// reset clears the stage valid bits only; data registers are not reset.
module triangle_face_normal import tfn_pkg::*; #(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  tfn_in_t  data_i,
  output logic     valid_o,
  input  logic     stall_i,
  output tfn_out_t data_o
);

`include "triangle_face_normal_defines.svh"

  localparam int F  = NORMAL_FRAC_BITS;
  localparam int NR = F + 1;
  localparam int NS = 8 + NR + 1;
  localparam int RW = 4 * COORD_WIDTH + 2 * F + 12;
  localparam int SW = 4 * COORD_WIDTH + 4;
  localparam int MW = 2 * COORD_WIDTH + 2;
  localparam int QW = F + 1;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[NS-1] = !v_q[NS-1] || !stall_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[NS-1];

  logic [MW-1:0]        mag [3];
  logic                 neg_c [3];
  logic signed [RW-1:0] rem_s [NR+1][3];
  logic signed [RW-1:0] acc_s [NR+1][3];
  logic [QW-1:0]        quo_s [NR+1][3];
  logic [SW-1:0]        sum_s [NR+1];
  logic                 neg_s [NR+1][3];
  logic                 deg_s [NR+1];

  tfn_cross #(
    .CoordWidth(COORD_WIDTH)
  ) u_cross (
    .clk_i (clk_i),
    .en_i  (en[3:0]),
    .data_i(data_i),
    .mag_o (mag),
    .neg_o (neg_c)
  );

  tfn_norm_sq #(
    .CoordWidth(COORD_WIDTH),
    .FracBits  (F)
  ) u_norm_sq (
    .clk_i(clk_i),
    .en_i (en[7:4]),
    .mag_i(mag),
    .neg_i(neg_c),
    .rem_o(rem_s[0]),
    .acc_o(acc_s[0]),
    .sum_o(sum_s[0]),
    .neg_o(neg_s[0]),
    .deg_o(deg_s[0])
  );

  assign quo_s[0][0] = '0;
  assign quo_s[0][1] = '0;
  assign quo_s[0][2] = '0;

  for (genvar j = 0; j < NR; j++) begin : g_root
    tfn_root_stage #(
      .CoordWidth(COORD_WIDTH),
      .FracBits  (F),
      .Bit       (F - j)
    ) u_stage (
      .clk_i(clk_i),
      .en_i (en[8+j]),
      .rem_i(rem_s[j]),
      .acc_i(acc_s[j]),
      .quo_i(quo_s[j]),
      .sum_i(sum_s[j]),
      .neg_i(neg_s[j]),
      .deg_i(deg_s[j]),
      .rem_o(rem_s[j+1]),
      .acc_o(acc_s[j+1]),
      .quo_o(quo_s[j+1]),
      .sum_o(sum_s[j+1]),
      .neg_o(neg_s[j+1]),
      .deg_o(deg_s[j+1])
    );
  end

  logic signed [QW:0]   sval [3];
  logic [OutWidth-1:0]  comp [3];
  tfn_out_t             out_d, out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sval[i] = neg_s[NR][i] ? -$signed({1'b0, quo_s[NR][i]}) : $signed({1'b0, quo_s[NR][i]});
      // zero length: the recurrence accepts every bit, so force the result
      comp[i] = deg_s[NR] ? '0 : OutWidth'(sval[i]);
    end
    out_d.normal_x   = comp[0];
    out_d.normal_y   = comp[1];
    out_d.normal_z   = comp[2];
    out_d.degenerate = deg_s[NR];
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign data_o = out_q;

  `TFN_ASSERT(a_deg_zero, valid_o && data_o.degenerate |-> data_o[3*OutWidth:1] == '0)
  `TFN_ASSERT(a_stall_cause, stall_o |-> valid_o && stall_i)
  `TFN_ASSERT(a_accept_lands, valid_i && !stall_o |=> v_q[0])
  `TFN_ASSERT(a_drain, valid_o && !stall_i && !v_q[NS-2] |=> !valid_o)

endmodule
